// File: rtl/midpoint_filter_3x3_assert.svh
// Assertion macros used by the midpoint filter control block (mpf_ctrl).
`ifndef MIDPOINT_FILTER_3X3_ASSERT_SVH
`define MIDPOINT_FILTER_3X3_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MPF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define MPF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mpf_pkg.sv
// Types and constants of the midpoint filter.
package mpf_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;
  localparam int unsigned MIN_SIZE       = 3;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned PIX_W      = CHAN_W * NUM_CHAN;
  localparam int unsigned CFG_SIZE_W = 12;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [CHAN_W-1:0]     RST_BORDER_VALUE = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BORDER_VALUE = 2'd2
  } mpf_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } mpf_cmd_e;

  // channel 0 red, 1 green, 2 blue (red in the lowest bits)
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t lower;
  } mpf_line_t;

  typedef struct packed {
    logic is_pixel;
    logic emit;
    logic border;
    logic frame_end;
  } mpf_meta_t;

endpackage

// File: rtl/midpoint_filter_3x3.sv
// Top level of the streaming 3x3 RGB midpoint filter.
//
//   channel  direction  handshake            payload
//   s_axis   in         tvalid / tready      tdata: red, green, blue; tuser: cmd
//   m_axis   out        tvalid / tready      tdata: red, green, blue; tlast: frame_end
//   cfg      in         valid / ready (=1)   index, data
//
// One item per cycle while the output is not stalled; an accepted item passes a stage
// that waits on the line memory read and a stage that holds the window, then the output register.
// A result appears width+1 pixels behind the input; flush items drain the tail.
// Reset clears control state only; line memory contents never reach an output.
// m_axis_tready_i low with a result waiting freezes the whole pipeline and
// s_axis_tready_o.
module midpoint_filter_3x3 #(
  parameter int unsigned MaxWidth  = mpf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MaxHeight = mpf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [mpf_pkg::PIX_W-1:0]      s_axis_tdata_i,  // in_red, in_green, in_blue
  input  logic                           s_axis_tuser_i,  // cmd
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [mpf_pkg::PIX_W-1:0]      m_axis_tdata_o,  // out_red, out_green, out_blue
  output logic                           m_axis_tlast_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mpf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mpf_pkg::CFG_SIZE_W-1:0] cfg_data_i
);

  localparam int unsigned ColW = $clog2(MaxWidth);

  logic                       advance, accept, s1_valid;
  logic [ColW-1:0]            rd_addr, s1_col;
  mpf_pkg::mpf_meta_t         s1_meta;
  mpf_pkg::pixel_t            in_px, s1_px, out_px;
  mpf_pkg::mpf_line_t         line;
  logic [mpf_pkg::CHAN_W-1:0] border_value;

  assign in_px           = s_axis_tdata_i;
  assign accept          = s_axis_tvalid_i && advance;
  assign s_axis_tready_o = advance;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tdata_o  = out_px;

  mpf_ctrl #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .advance_i      (advance),
    .accept_i       (accept),
    .cmd_i          (s_axis_tuser_i),
    .px_i           (in_px),
    .rd_addr_o      (rd_addr),
    .s1_valid_o     (s1_valid),
    .s1_meta_o      (s1_meta),
    .s1_px_o        (s1_px),
    .s1_col_o       (s1_col),
    .border_value_o (border_value)
  );

  mpf_line_mem #(
    .MaxWidth (MaxWidth)
  ) u_line_mem (
    .clk_i      (clk_i),
    .advance_i  (advance),
    .rd_addr_i  (rd_addr),
    .s1_valid_i (s1_valid),
    .s1_meta_i  (s1_meta),
    .s1_col_i   (s1_col),
    .s1_px_i    (s1_px),
    .line_o     (line)
  );

  mpf_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s1_valid_i     (s1_valid),
    .s1_meta_i      (s1_meta),
    .s1_px_i        (s1_px),
    .line_i         (line),
    .border_value_i (border_value),
    .m_tready_i     (m_axis_tready_i),
    .advance_o      (advance),
    .out_valid_o    (m_axis_tvalid_o),
    .out_px_o       (out_px),
    .out_last_o     (m_axis_tlast_o)
  );

endmodule

// File: rtl/mpf_ctrl.sv
// Position counters, pending count, config registers and first pipeline stage.
`include "midpoint_filter_3x3_assert.svh"

module mpf_ctrl #(
  parameter int unsigned MaxWidth  = mpf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MaxHeight = mpf_pkg::DEF_MAX_HEIGHT,
  localparam int unsigned ColW = $clog2(MaxWidth),
  localparam int unsigned RowW = $clog2(MaxHeight)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [mpf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mpf_pkg::CFG_SIZE_W-1:0]      cfg_data_i,
  input  logic                                advance_i,
  input  logic                                accept_i,
  input  logic                                cmd_i,
  input  mpf_pkg::pixel_t                     px_i,
  output logic [ColW-1:0]                     rd_addr_o,
  output logic                                s1_valid_o,
  output mpf_pkg::mpf_meta_t                  s1_meta_o,
  output mpf_pkg::pixel_t                     s1_px_o,
  output logic [ColW-1:0]                     s1_col_o,
  output logic [mpf_pkg::CHAN_W-1:0]          border_value_o
);

  localparam int unsigned SzW = $clog2(MaxWidth + 2);
  localparam int unsigned HtW = $clog2(MaxHeight + 1);

  logic [mpf_pkg::CFG_SIZE_W-1:0] width_q, height_q;
  logic [mpf_pkg::CHAN_W-1:0]     border_q;

  logic [ColW-1:0] in_col_q, in_col_d;
  logic [ColW-1:0] out_col_q, out_col_d;
  logic [RowW-1:0] out_row_q, out_row_d;
  logic [SzW-1:0]  pend_q, pend_d;

  logic [SzW-1:0] w_eff, w_m1, w_p1;
  logic [HtW-1:0] h_eff, h_m1;
  logic           size_wr, is_flush, emit, col_last, out_col_last, out_row_last;

  logic               s1_valid_q;
  mpf_pkg::mpf_meta_t s1_meta_q, meta;
  mpf_pkg::pixel_t    s1_px_q;
  logic [ColW-1:0]    s1_col_q;

  always_comb begin
    if (32'(width_q) < mpf_pkg::MIN_SIZE) begin
      w_eff = SzW'(mpf_pkg::MIN_SIZE);
    end else if (32'(width_q) > MaxWidth) begin
      w_eff = SzW'(MaxWidth);
    end else begin
      w_eff = SzW'(width_q);
    end
    if (32'(height_q) < mpf_pkg::MIN_SIZE) begin
      h_eff = HtW'(mpf_pkg::MIN_SIZE);
    end else if (32'(height_q) > MaxHeight) begin
      h_eff = HtW'(MaxHeight);
    end else begin
      h_eff = HtW'(height_q);
    end
  end

  assign w_m1 = w_eff - SzW'(1);
  assign w_p1 = w_eff + SzW'(1);
  assign h_m1 = h_eff - HtW'(1);

  assign size_wr = cfg_valid_i &&
                   (cfg_index_i == mpf_pkg::REG_IMAGE_WIDTH ||
                    cfg_index_i == mpf_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mpf_pkg::RST_IMAGE_WIDTH;
      height_q <= mpf_pkg::RST_IMAGE_HEIGHT;
      border_q <= mpf_pkg::RST_BORDER_VALUE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mpf_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        mpf_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        mpf_pkg::REG_BORDER_VALUE: border_q <= cfg_data_i[mpf_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign is_flush     = (cmd_i == mpf_pkg::CMD_FLUSH);
  assign col_last     = (SzW'(in_col_q) == w_m1);
  assign out_col_last = (SzW'(out_col_q) == w_m1);
  assign out_row_last = (HtW'(out_row_q) == h_m1);
  assign emit         = is_flush ? (pend_q != '0) : (pend_q == w_p1);

  always_comb begin
    meta.is_pixel  = !is_flush;
    meta.emit      = emit;
    meta.border    = is_flush || (out_row_q == '0) || (out_col_q == '0) ||
                     out_row_last || out_col_last;
    meta.frame_end = out_row_last && out_col_last;
  end

  always_comb begin
    in_col_d  = in_col_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend_d    = pend_q;
    if (accept_i) begin
      if (!is_flush) begin
        in_col_d = col_last ? '0 : in_col_q + ColW'(1);
        if (!emit) begin
          pend_d = pend_q + SzW'(1);
        end
      end else if (emit) begin
        pend_d = pend_q - SzW'(1);
      end
      if (emit) begin
        if (out_col_last) begin
          out_col_d = '0;
          out_row_d = out_row_last ? '0 : out_row_q + RowW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else if (size_wr) begin
      in_col_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pend_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance_i) begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s1_meta_q <= meta;
      s1_px_q   <= px_i;
      s1_col_q  <= in_col_q;
    end
  end

  assign rd_addr_o      = in_col_q;
  assign s1_valid_o     = s1_valid_q;
  assign s1_meta_o      = s1_meta_q;
  assign s1_px_o        = s1_px_q;
  assign s1_col_o       = s1_col_q;
  assign border_value_o = border_q;

  `MPF_ASSERT_IMP(a_pend_bound, 1'b1, pend_q <= w_p1, "pending count above width plus one")
  `MPF_ASSERT_NXT(a_size_restart, size_wr, pend_q == '0 && in_col_q == '0 && out_col_q == '0,
                  "size write did not restart the frame")
  `MPF_ASSERT_NXT(a_emit_hold, accept_i && !is_flush && emit && !size_wr,
                  pend_q == $past(pend_q), "pending count moved on a pixel with output")

endmodule

// File: rtl/mpf_line_mem.sv
// Two line stores in one memory, read in the stage ahead of the write-back.
module mpf_line_mem #(
  parameter int unsigned MaxWidth = mpf_pkg::DEF_MAX_WIDTH,
  localparam int unsigned ColW = $clog2(MaxWidth)
) (
  input  logic               clk_i,
  input  logic               advance_i,
  input  logic [ColW-1:0]    rd_addr_i,
  input  logic               s1_valid_i,
  input  mpf_pkg::mpf_meta_t s1_meta_i,
  input  logic [ColW-1:0]    s1_col_i,
  input  mpf_pkg::pixel_t    s1_px_i,
  output mpf_pkg::mpf_line_t line_o
);

  mpf_pkg::mpf_line_t mem_q [MaxWidth];
  mpf_pkg::mpf_line_t rdata_q;
  mpf_pkg::mpf_line_t wdata;

  // rows move up one store; the read of the next column never hits the
  // column written here since a row has at least three pixels
  assign wdata.upper = rdata_q.lower;
  assign wdata.lower = s1_px_i;

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      rdata_q <= mem_q[rd_addr_i];
      if (s1_valid_i && s1_meta_i.is_pixel) begin
        mem_q[s1_col_i] <= wdata;
      end
    end
  end

  assign line_o = rdata_q;

endmodule

// File: rtl/mpf_window.sv
// Column min/max window, midpoint and output register.
module mpf_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s1_valid_i,
  input  mpf_pkg::mpf_meta_t         s1_meta_i,
  input  mpf_pkg::pixel_t            s1_px_i,
  input  mpf_pkg::mpf_line_t         line_i,
  input  logic [mpf_pkg::CHAN_W-1:0] border_value_i,
  input  logic                       m_tready_i,
  output logic                       advance_o,
  output logic                       out_valid_o,
  output mpf_pkg::pixel_t            out_px_o,
  output logic                       out_last_o
);

  localparam int unsigned CW = mpf_pkg::CHAN_W;
  localparam int unsigned NC = mpf_pkg::NUM_CHAN;

  function automatic logic [CW-1:0] cmin(logic [CW-1:0] a, logic [CW-1:0] b);
    cmin = (a < b) ? a : b;
  endfunction

  function automatic logic [CW-1:0] cmax(logic [CW-1:0] a, logic [CW-1:0] b);
    cmax = (a > b) ? a : b;
  endfunction

  mpf_pkg::pixel_t    col_lo, col_hi;
  mpf_pkg::pixel_t    win_lo_q [3];
  mpf_pkg::pixel_t    win_hi_q [3];
  logic               s2_valid_q;
  mpf_pkg::mpf_meta_t s2_meta_q;
  mpf_pkg::pixel_t    result;
  logic               out_valid_q, out_last_q;
  mpf_pkg::pixel_t    out_px_q;
  logic               advance;

  assign advance = !out_valid_q || m_tready_i;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      col_lo[k] = cmin(cmin(line_i.upper[k], line_i.lower[k]), s1_px_i[k]);
      col_hi[k] = cmax(cmax(line_i.upper[k], line_i.lower[k]), s1_px_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_i && s1_meta_i.is_pixel) begin
      win_lo_q[0] <= win_lo_q[1];
      win_lo_q[1] <= win_lo_q[2];
      win_lo_q[2] <= col_lo;
      win_hi_q[0] <= win_hi_q[1];
      win_hi_q[1] <= win_hi_q[2];
      win_hi_q[2] <= col_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_meta_q <= s1_meta_i;
    end
  end

  always_comb begin
    logic [CW-1:0] lo, hi;
    logic [CW:0]   sum;
    for (int k = 0; k < NC; k++) begin
      lo  = cmin(cmin(win_lo_q[0][k], win_lo_q[1][k]), win_lo_q[2][k]);
      hi  = cmax(cmax(win_hi_q[0][k], win_hi_q[1][k]), win_hi_q[2][k]);
      sum = {1'b0, lo} + {1'b0, hi};
      result[k] = s2_meta_q.border ? border_value_i : sum[CW:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s2_valid_q && s2_meta_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_px_q   <= result;
      out_last_q <= s2_meta_q.frame_end;
    end
  end

  assign advance_o   = advance;
  assign out_valid_o = out_valid_q;
  assign out_px_o    = out_px_q;
  assign out_last_o  = out_last_q;

endmodule
